// ===== src/uv_sphere_vertex_generator_top_defines.svh =====
// Assertion macros for the UV-sphere vertex generator checker.
// Needs signals i_clk and i_rst_n in the including scope.
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// clocked check, off while in reset
`define UVSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check, active through reset
`define UVSG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/uvsg_pkg.sv =====
// Shared types, constants and tables of the UV-sphere vertex generator.
// No dependencies.
package uvsg_pkg;

    localparam int IDX_W         = 9;
    localparam int CNT_W         = 9;
    localparam int TEX_W         = 17;
    localparam int VTX_W         = 17;
    localparam int ANGLE_W       = 32;
    localparam int TRIG_W        = 33;
    localparam int CORDIC_ITERS  = 24;
    localparam int CORDIC_LAT    = CORDIC_ITERS + 1;
    localparam int DIV_NUM_W     = IDX_W + 16;
    localparam int DIV_LAT       = DIV_NUM_W;
    localparam int CORDIC_GAIN_Q30 = 652032874;

    localparam int DEF_MAX_STACKS = 256;
    localparam int DEF_MAX_SLICES = 256;
    localparam int DEF_FRAC_BITS  = 14;

    localparam logic [CNT_W-1:0] STACK_RESET = CNT_W'(16);
    localparam logic [CNT_W-1:0] SLICE_RESET = CNT_W'(32);

    typedef enum logic {
        CFG_STACK_COUNT = 1'b0,
        CFG_SLICE_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] below;
        logic             upper;
        logic             lower;
    } t_side;

    localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

// ===== src/uvsg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on uvsg_pkg.
module uvsg_div import uvsg_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = CNT_W,
    parameter int Q_W   = TEX_W
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [Q_W-1:0]   r_quo [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [Q_W-1:0]   quo_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
        end
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, i_den};
        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? DEN_W'(trial - {1'b0, i_den}) : DEN_W'(trial);
            r_num[k] <= {num_in[NUM_W-2:0], 1'b0};
            r_quo[k] <= {quo_in[Q_W-2:0], ge};
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

// ===== src/uvsg_cordic.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a turn fraction, Q2.30.
// Depends on uvsg_pkg.
module uvsg_cordic import uvsg_pkg::*; (
    input  logic                     i_clk,
    input  logic [ANGLE_W-1:0]       i_angle,
    output logic signed [TRIG_W-1:0] o_sin,
    output logic signed [TRIG_W-1:0] o_cos
);

    localparam int XW = TRIG_W + 1;

    logic signed [XW-1:0] r_x [CORDIC_ITERS];
    logic signed [XW-1:0] r_y [CORDIC_ITERS];
    logic signed [XW-1:0] r_z [CORDIC_ITERS];
    logic                 r_neg [CORDIC_ITERS];
    logic signed [TRIG_W-1:0] r_sin, r_cos, n_sin, n_cos;

    logic                 neg0;
    logic [ANGLE_W-1:0]   fold;
    logic signed [XW-1:0] z0;

    always_comb begin
        neg0 = (i_angle[31:30] == 2'd1) || (i_angle[31:30] == 2'd2);
        fold = neg0 ? {~i_angle[31], i_angle[30:0]} : i_angle;
        z0   = {{(XW-ANGLE_W){fold[ANGLE_W-1]}}, fold};
    end

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_it
        logic signed [XW-1:0] x_in, y_in, z_in, atan_k;
        logic                 neg_in;
        if (k == 0) begin : g_first
            assign x_in   = XW'(CORDIC_GAIN_Q30);
            assign y_in   = '0;
            assign z_in   = z0;
            assign neg_in = neg0;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign y_in   = r_y[k-1];
            assign z_in   = r_z[k-1];
            assign neg_in = r_neg[k-1];
        end
        assign atan_k = XW'(ATAN_TURNS[k]);
        always_ff @(posedge i_clk) begin
            if (!z_in[XW-1]) begin
                r_x[k] <= x_in - (y_in >>> k);
                r_y[k] <= y_in + (x_in >>> k);
                r_z[k] <= z_in - atan_k;
            end else begin
                r_x[k] <= x_in + (y_in >>> k);
                r_y[k] <= y_in - (x_in >>> k);
                r_z[k] <= z_in + atan_k;
            end
            r_neg[k] <= neg_in;
        end
    end

    always_comb begin
        n_sin = r_neg[CORDIC_ITERS-1] ? TRIG_W'(-r_y[CORDIC_ITERS-1])
                                      : TRIG_W'(r_y[CORDIC_ITERS-1]);
        n_cos = r_neg[CORDIC_ITERS-1] ? TRIG_W'(-r_x[CORDIC_ITERS-1])
                                      : TRIG_W'(r_x[CORDIC_ITERS-1]);
    end

    always_ff @(posedge i_clk) begin
        r_sin <= n_sin;
        r_cos <= n_cos;
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== src/uv_sphere_vertex_generator_top.sv =====
// UV-sphere vertex generator top level. Depends on uvsg_pkg, uvsg_div, uvsg_cordic.
// Throughput: one word per cycle; busy stays low, a start is taken every cycle.
// A start passes the input registers, two 25-stage dividers, two 25-stage CORDIC
// pipes, the product registers and the output registers before o_done rises.
// Reset: synchronous, active low; clears the valid pipe and loads counts 16 and 32.
module uv_sphere_vertex_generator_top import uvsg_pkg::*; #(
    parameter int MAX_STACKS = DEF_MAX_STACKS,
    parameter int MAX_SLICES = DEF_MAX_SLICES,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [CNT_W-1:0]          i_cfg_data,
    input  logic [IDX_W-1:0]          i_stack_index,
    input  logic [IDX_W-1:0]          i_slice_index,
    output logic                      o_done,
    output logic signed [FRAC_BITS:0]   o_pos_x,
    output logic signed [FRAC_BITS:0]   o_pos_y,
    output logic signed [FRAC_BITS:0]   o_pos_z,
    output logic signed [FRAC_BITS+1:0] o_normal_x,
    output logic signed [FRAC_BITS+1:0] o_normal_y,
    output logic signed [FRAC_BITS+1:0] o_normal_z,
    output logic [TEX_W-1:0]          o_tex_u,
    output logic [TEX_W-1:0]          o_tex_v,
    output logic [VTX_W-1:0]          o_vertex_number,
    output logic [VTX_W-1:0]          o_below_number,
    output logic                      o_upper_tri_valid,
    output logic                      o_lower_tri_valid
);

    localparam int POS_W  = FRAC_BITS + 1;
    localparam int NRM_W  = FRAC_BITS + 2;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int NS     = 60 - FRAC_BITS;
    localparam int PS     = 61 - FRAC_BITS;
    localparam int LAT    = 1 + DIV_LAT + CORDIC_LAT + 2;
    localparam int TEX_D  = CORDIC_LAT + 2;
    localparam logic signed [PROD_W-1:0] NLIM = PROD_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] PLIM = PROD_W'(1) << (FRAC_BITS - 1);

    function automatic logic signed [PROD_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] v,
        input int                       s,
        input logic signed [PROD_W-1:0] lim
    );
        logic signed [PROD_W:0] t;
        logic signed [PROD_W:0] r;
        t = {v[PROD_W-1], v} + ((PROD_W+1)'(1) << (s - 1));
        r = t >>> s;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return PROD_W'(r);
    endfunction

    logic [CNT_W-1:0] r_stack_cnt, r_slice_cnt;
    logic [CNT_W-1:0] st, sl;
    logic [IDX_W-1:0] ic, jc;
    logic             accept;
    t_side            n_side;

    logic [LAT-1:0]       r_vld;
    t_side                r_side [LAT];
    logic [DIV_NUM_W-1:0] r_num_v, r_num_u;
    logic [TEX_W-1:0]     quo_v, quo_u;
    logic [TEX_W-1:0]     r_tv [TEX_D];
    logic [TEX_W-1:0]     r_tu [TEX_D];

    logic signed [TRIG_W-1:0] th_sin, th_cos, ph_sin, ph_cos;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [PROD_W-1:0] n_nx, n_ny, n_nz, n_px, n_py, n_pz;
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic signed [NRM_W-1:0]  r_nrm_x, r_nrm_y, r_nrm_z;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_cnt <= STACK_RESET;
            r_slice_cnt <= SLICE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STACK_COUNT: r_stack_cnt <= i_cfg_data;
                CFG_SLICE_COUNT: r_slice_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_stack_cnt == '0)             st = CNT_W'(1);
        else if (r_stack_cnt > MAX_STACKS) st = CNT_W'(MAX_STACKS);
        else                               st = r_stack_cnt;
        if (r_slice_cnt == '0)             sl = CNT_W'(1);
        else if (r_slice_cnt > MAX_SLICES) sl = CNT_W'(MAX_SLICES);
        else                               sl = r_slice_cnt;
        ic = (i_stack_index > st) ? st : i_stack_index;
        jc = (i_slice_index > sl) ? sl : i_slice_index;
        n_side.vertex = VTX_W'(ic) * (VTX_W'(sl) + VTX_W'(1)) + VTX_W'(jc);
        n_side.below  = VTX_W'(n_side.vertex + sl + 1'b1);
        n_side.upper  = (ic < st) && (jc < sl) && (ic != '0);
        n_side.lower  = (ic < st) && (jc < sl) && (ic != st - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        r_num_v   <= {ic, 16'b0} + DIV_NUM_W'(st >> 1);
        r_num_u   <= {jc, 16'b0} + DIV_NUM_W'(sl >> 1);
        for (int k = 1; k < LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
        r_tv[0] <= quo_v;
        r_tu[0] <= quo_u;
        for (int k = 1; k < TEX_D; k++) begin
            r_tv[k] <= r_tv[k-1];
            r_tu[k] <= r_tu[k-1];
        end
    end

    uvsg_div u_div_v (.i_clk(i_clk), .i_num(r_num_v), .i_den(st), .o_quo(quo_v));
    uvsg_div u_div_u (.i_clk(i_clk), .i_num(r_num_u), .i_den(sl), .o_quo(quo_u));

    uvsg_cordic u_cordic_theta (
        .i_clk   (i_clk),
        .i_angle ({quo_v, 15'b0}),
        .o_sin   (th_sin),
        .o_cos   (th_cos)
    );

    uvsg_cordic u_cordic_phi (
        .i_clk   (i_clk),
        .i_angle ({quo_u[15:0], 16'b0}),
        .o_sin   (ph_sin),
        .o_cos   (ph_cos)
    );

    always_ff @(posedge i_clk) begin
        r_px <= th_sin * ph_cos;
        r_pz <= th_sin * ph_sin;
        r_py <= {{(PROD_W-TRIG_W-30){th_cos[TRIG_W-1]}}, th_cos, 30'b0};
    end

    always_comb begin
        n_nx = round_sat(r_px, NS, NLIM);
        n_ny = round_sat(r_py, NS, NLIM);
        n_nz = round_sat(r_pz, NS, NLIM);
        n_px = round_sat(r_px, PS, PLIM);
        n_py = round_sat(r_py, PS, PLIM);
        n_pz = round_sat(r_pz, PS, PLIM);
    end

    always_ff @(posedge i_clk) begin
        r_nrm_x <= n_nx[NRM_W-1:0];
        r_nrm_y <= n_ny[NRM_W-1:0];
        r_nrm_z <= n_nz[NRM_W-1:0];
        r_pos_x <= n_px[POS_W-1:0];
        r_pos_y <= n_py[POS_W-1:0];
        r_pos_z <= n_pz[POS_W-1:0];
    end

    assign o_done            = r_vld[LAT-1];
    assign o_pos_x           = r_pos_x;
    assign o_pos_y           = r_pos_y;
    assign o_pos_z           = r_pos_z;
    assign o_normal_x        = r_nrm_x;
    assign o_normal_y        = r_nrm_y;
    assign o_normal_z        = r_nrm_z;
    assign o_tex_u           = r_tu[TEX_D-1];
    assign o_tex_v           = r_tv[TEX_D-1];
    assign o_vertex_number   = r_side[LAT-1].vertex;
    assign o_below_number    = r_side[LAT-1].below;
    assign o_upper_tri_valid = r_side[LAT-1].upper;
    assign o_lower_tri_valid = r_side[LAT-1].lower;

endmodule

// ===== src/uvsg_checker.sv =====
// Port-level checks of the UV-sphere vertex generator, bound to the top level.
// Depends on uvsg_pkg and uv_sphere_vertex_generator_top_defines.svh.
`include "uv_sphere_vertex_generator_top_defines.svh"
module uvsg_checker import uvsg_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        busy,
    input logic                        o_done,
    input logic signed [FRAC_BITS+1:0] o_normal_y,
    input logic [TEX_W-1:0]            o_tex_v,
    input logic [VTX_W-1:0]            o_vertex_number,
    input logic [VTX_W-1:0]            o_below_number,
    input logic                        o_upper_tri_valid
);

    localparam int NLIM = 1 << FRAC_BITS;

    `UVSG_ASSERT_RST(a_rst_clears_done, !i_rst_n |=> !o_done, "done after reset")
    `UVSG_ASSERT(a_never_busy, busy == 1'b0, "busy raised")
    `UVSG_ASSERT(a_below_after, o_done |-> o_below_number > o_vertex_number, "below index low")
    `UVSG_ASSERT(a_upper_top, o_done && o_upper_tri_valid |-> o_tex_v != '0, "upper at top row")
    `UVSG_ASSERT(a_ny_range, o_done |-> o_normal_y <= NLIM && o_normal_y >= -NLIM, "ny range")

endmodule

bind uv_sphere_vertex_generator_top uvsg_checker #(.FRAC_BITS(FRAC_BITS)) u_uvsg_checker (.*);
